@@ design/r64arm_pkg.sv @@
// Shared types, character codes and helper functions for the radix-64 armor decoder.
package r64arm_pkg;

  // Character codes seen in armored text.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Symbol values of the alphabet sections.
  localparam logic [7:0] SYM_LOWER_BASE = 8'd26;
  localparam logic [7:0] SYM_DIGIT_BASE = 8'd52;
  localparam logic [5:0] SYM_PLUS_VAL   = 6'd62;
  localparam logic [5:0] SYM_SLASH_VAL  = 6'd63;

  // CRC-24 settings.
  localparam logic [23:0] CRC_INIT = 24'hB704CE;
  localparam logic [24:0] CRC_POLY = 25'h1864CFB;

  // Message framing constants.
  localparam logic [2:0]  CHECK_LEN   = 3'd4;
  localparam logic [1:0]  GROUP_LAST  = 2'd3;
  localparam int          GROUP_BYTES = 3;
  localparam logic [23:0] CAP_RESET   = 24'hFFFFFF;
  localparam int          Q_DEPTH     = 2;

  // Result beat kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HIGH_BIT     = 3'd1,
    ST_BAD_SYMBOL   = 3'd2,
    ST_CRC_OVERLONG = 3'd3,
    ST_PARTIAL      = 3'd4,
    ST_CRC_MISSING  = 3'd5,
    ST_CRC_MISMATCH = 3'd6,
    ST_OUTPUT_FULL  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_GROUP,
    OP_ERROR
  } tok_op_t;

  // One classified character: its 6-bit value, whether it is outside the
  // alphabet, and whether it is the pad character.
  typedef struct packed {
    logic       eq;
    logic       bad;
    logic [5:0] val;
  } gchar_t;

  // Work handed from the front to the back through the queue.
  typedef struct packed {
    tok_op_t         op;
    logic            eot;
    status_t         err_code;
    logic [2:0][7:0] bytes;
    logic [1:0]      nb;
    logic            group_bad;
    logic            partial;
    logic            check_full;
    logic            check_bad;
    logic [23:0]     check_value;
  } tok_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DATA,
    BK_STATUS
  } back_state_t;

  // Classify one character against the radix-64 alphabet.
  function automatic gchar_t sym_lookup(logic [7:0] c);
    gchar_t s;
    s.eq  = (c == CH_EQ);
    s.bad = 1'b0;
    s.val = '0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      s.val = 6'(c - CH_UP_A);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      s.val = 6'(c - CH_LO_A + SYM_LOWER_BASE);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      s.val = 6'(c - CH_ZERO + SYM_DIGIT_BASE);
    end else if (c == CH_PLUS) begin
      s.val = SYM_PLUS_VAL;
    end else if (c == CH_SLASH) begin
      s.val = SYM_SLASH_VAL;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

  // Advance the CRC-24 by one byte, MSB first.
  function automatic logic [23:0] crc_byte(logic [23:0] crc, logic [7:0] b);
    logic [24:0] r;
    r = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      r = {r[23:0], 1'b0};
      if (r[24]) begin
        r = r ^ CRC_POLY;
      end
    end
    return r[23:0];
  endfunction

endpackage

@@ design/radix64_armor_decoder_crc24.sv @@
// Top level of the radix-64 armor decoder with CRC-24 check.
//
// Takes one armored text character per input beat and returns a data beat for
// every decoded byte, then one status beat per message that carries the status
// code and the decoded length. The front end takes one character per cycle as
// long as its two-entry token queue has room; blank and framing characters
// cost nothing downstream. The back end takes a token from the queue while idle
// and then sends the output beats for it, taking no new token until they are
// all sent. Long runs of text settle near one character per cycle while the
// output is not stalled, set by the back end's one-beat-per-cycle output
// sequencer and CRC update. The user must write the output capacity register
// through cfg_write and cfg_data only while the block is idle; the block itself
// does not enforce this. The register resets to all ones.
module radix64_armor_decoder_crc24 #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [2:0]  status,
  output logic [23:0] decoded_length,
  output logic        last
);
  import r64arm_pkg::*;

  logic q_push;
  tok_t q_tok_in;
  logic q_full;
  logic q_pop;
  tok_t q_tok_out;
  logic q_empty;

  // Character classification and group assembly.
  r64arm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (q_push),
    .push_tok    (q_tok_in)
  );

  // Token queue between the two halves.
  r64arm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (q_tok_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_tok  (q_tok_out),
    .empty    (q_empty)
  );

  // Byte emission, CRC and message close.
  r64arm_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .q_empty        (q_empty),
    .q_tok          (q_tok_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .status         (status),
    .decoded_length (decoded_length),
    .last           (last)
  );

`ifndef ASSERT_OFF
  // The front never writes a token into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("token pushed into full queue");

  // The back never takes a token from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("token popped from empty queue");

  // A data beat carries no status, length or last flag.
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DATA) |->
      (status == ST_OK && decoded_length == '0 && !last))
    else $error("data beat with status fields set");

  // Every status beat closes the message.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_STATUS) |-> last)
    else $error("status beat without last");
`endif

endmodule

@@ design/r64arm_front.sv @@
// Front end: accepts characters, tracks line and checksum framing, and builds groups.
module r64arm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_in,
  input  logic               end_of_text,
  input  logic               q_full,
  output logic               push,
  output r64arm_pkg::tok_t   push_tok
);
  import r64arm_pkg::*;

  logic        line_start, line_start_next;
  logic        in_checksum, in_checksum_next;
  logic        input_stopped, input_stopped_next;
  logic [1:0]  group_count, group_count_next;
  logic [2:0]  check_count, check_count_next;
  logic        check_bad, check_bad_next;
  logic [23:0] check_value, check_value_next;
  gchar_t      group_chars [3];
  logic        group_we;
  gchar_t      sym;
  logic        accept;
  tok_t        tok;
  logic        g_bad;
  logic [1:0]  g_nb;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign sym      = sym_lookup(char_in);

  // Decode of a complete group: three stored symbols and the current one.
  always_comb begin
    if (group_chars[2].eq) begin
      g_bad = group_chars[0].bad | group_chars[1].bad;
      g_nb  = 2'd1;
    end else if (sym.eq) begin
      g_bad = group_chars[0].bad | group_chars[1].bad | group_chars[2].bad;
      g_nb  = 2'd2;
    end else begin
      g_bad = group_chars[0].bad | group_chars[1].bad | group_chars[2].bad | sym.bad;
      g_nb  = 2'd3;
    end
  end

  // Classify the character and work out the framing state after it.
  always_comb begin
    line_start_next    = line_start;
    in_checksum_next   = in_checksum;
    input_stopped_next = input_stopped;
    group_count_next   = group_count;
    check_count_next   = check_count;
    check_bad_next     = check_bad;
    check_value_next   = check_value;
    group_we           = 1'b0;

    tok           = '0;
    tok.op        = OP_NONE;
    tok.err_code  = ST_OK;
    tok.eot       = end_of_text;
    tok.bytes[0]  = {group_chars[0].val, group_chars[1].val[5:4]};
    tok.bytes[1]  = {group_chars[1].val[3:0], group_chars[2].val[5:2]};
    tok.bytes[2]  = {group_chars[2].val[1:0], sym.val};
    tok.nb        = g_nb;
    tok.group_bad = g_bad;

    if (!input_stopped) begin
      if (char_in[7]) begin
        tok.op       = OP_ERROR;
        tok.err_code = ST_HIGH_BIT;
      end else if (char_in inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR}) begin
        // Blank characters leave no trace.
      end else if (char_in == CH_LF) begin
        line_start_next = 1'b1;
      end else if (in_checksum) begin
        if (line_start) begin
          input_stopped_next = 1'b1;
        end else if (check_count >= CHECK_LEN) begin
          tok.op       = OP_ERROR;
          tok.err_code = ST_CRC_OVERLONG;
        end else begin
          check_value_next = {check_value[17:0], sym.val};
          check_bad_next   = check_bad | sym.bad;
          check_count_next = check_count + 3'd1;
        end
      end else if (line_start && sym.eq) begin
        line_start_next  = 1'b0;
        in_checksum_next = 1'b1;
      end else begin
        line_start_next = 1'b0;
        if (group_count == GROUP_LAST) begin
          tok.op           = OP_GROUP;
          group_count_next = '0;
        end else begin
          group_we         = 1'b1;
          group_count_next = group_count + 2'd1;
        end
      end
    end

    tok.partial     = (group_count_next != '0);
    tok.check_full  = (check_count_next == CHECK_LEN);
    tok.check_bad   = check_bad_next;
    tok.check_value = check_value_next;
  end

  assign push     = accept && (tok.op != OP_NONE || end_of_text);
  assign push_tok = tok;

  // Framing state; the end of a message returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_start    <= 1'b1;
      in_checksum   <= 1'b0;
      input_stopped <= 1'b0;
      group_count   <= '0;
      check_count   <= '0;
      check_bad     <= 1'b0;
    end else if (accept) begin
      if (end_of_text) begin
        line_start    <= 1'b1;
        in_checksum   <= 1'b0;
        input_stopped <= 1'b0;
        group_count   <= '0;
        check_count   <= '0;
        check_bad     <= 1'b0;
      end else begin
        line_start    <= line_start_next;
        in_checksum   <= in_checksum_next;
        input_stopped <= input_stopped_next;
        group_count   <= group_count_next;
        check_count   <= check_count_next;
        check_bad     <= check_bad_next;
      end
    end
  end

  // Character stores carry payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      check_value <= check_value_next;
      if (group_we) begin
        group_chars[group_count] <= sym;
      end
    end
  end

endmodule

@@ design/r64arm_queue.sv @@
// Short register queue of work tokens between the front and the back.
module r64arm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  r64arm_pkg::tok_t push_tok,
  output logic             full,
  input  logic             pop,
  output r64arm_pkg::tok_t pop_tok,
  output logic             empty
);
  import r64arm_pkg::*;

  localparam int QP = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  tok_t          slots [Q_DEPTH];
  logic [QP-1:0] wr_ptr;
  logic [QP-1:0] rd_ptr;
  logic [QP:0]   count;

  assign full    = (count == (QP+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_tok = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

endmodule

@@ design/r64arm_back.sv @@
// Back end: emits decoded bytes, runs the CRC and length count, and closes each message.
module r64arm_back #(
  parameter int LENGTH_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [23:0]      cfg_data,
  input  logic             q_empty,
  input  r64arm_pkg::tok_t q_tok,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             kind,
  output logic [7:0]       data_byte,
  output logic [2:0]       status,
  output logic [23:0]      decoded_length,
  output logic             last
);
  import r64arm_pkg::*;

  localparam int CW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

  back_state_t            state, state_next;
  tok_t                   cur, cur_next;
  status_t                err, err_next;
  logic [1:0]             idx, idx_next;
  logic [23:0]            crc, crc_next;
  logic [LENGTH_BITS-1:0] bytes_out, bytes_next;
  logic                   error_drop, drop_next;
  logic [23:0]            capacity;

  logic [CW-1:0]          cap_ext;
  logic [CW-1:0]          len_mask;
  logic [CW-1:0]          cap;
  logic                   room_ok;
  status_t                end_code;
  logic                   can_emit;
  logic                   emit;
  logic                   e_kind;
  logic [7:0]             e_byte;
  status_t                e_status;

  // Free room for a whole group, with the capacity capped to the length width.
  assign cap_ext  = CW'(capacity);
  assign len_mask = CW'({LENGTH_BITS{1'b1}});
  assign cap      = (cap_ext < len_mask) ? cap_ext : len_mask;
  assign room_ok  = (CW+1)'(cap) >= (CW+1)'(bytes_out) + (CW+1)'(GROUP_BYTES);

  // Checks made when the message ends.
  always_comb begin
    if (cur.partial) begin
      end_code = ST_PARTIAL;
    end else if (!cur.check_full) begin
      end_code = ST_CRC_MISSING;
    end else if (cur.check_bad || cur.check_value != crc) begin
      end_code = ST_CRC_MISMATCH;
    end else begin
      end_code = ST_OK;
    end
  end

  assign can_emit = !out_valid || !out_stall;

  // Sequencer: take a token, then emit one beat per cycle while the output is not stalled.
  always_comb begin
    state_next = state;
    cur_next   = cur;
    err_next   = err;
    idx_next   = idx;
    crc_next   = crc;
    bytes_next = bytes_out;
    drop_next  = error_drop;
    q_pop      = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_DATA;
    e_byte     = '0;
    e_status   = ST_OK;

    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_next = q_tok;
          err_next = ST_OK;
          idx_next = '0;
          if (error_drop) begin
            if (q_tok.eot) begin
              drop_next  = 1'b0;
              crc_next   = CRC_INIT;
              bytes_next = '0;
            end
          end else begin
            case (q_tok.op)
              OP_GROUP: begin
                if (!room_ok) begin
                  err_next   = ST_OUTPUT_FULL;
                  state_next = BK_STATUS;
                end else if (q_tok.group_bad) begin
                  err_next   = ST_BAD_SYMBOL;
                  state_next = BK_STATUS;
                end else begin
                  state_next = BK_DATA;
                end
              end
              OP_ERROR: begin
                err_next   = q_tok.err_code;
                state_next = BK_STATUS;
              end
              default: begin
                if (q_tok.eot) begin
                  state_next = BK_STATUS;
                end
              end
            endcase
          end
        end
      end
      BK_DATA: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_byte     = cur.bytes[idx];
          crc_next   = crc_byte(crc, cur.bytes[idx]);
          bytes_next = bytes_out + 1'b1;
          idx_next   = idx + 2'd1;
          if (idx == cur.nb - 2'd1) begin
            state_next = cur.eot ? BK_STATUS : BK_IDLE;
          end
        end
      end
      BK_STATUS: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_kind     = KIND_STATUS;
          e_status   = (err != ST_OK) ? err : end_code;
          state_next = BK_IDLE;
          if (cur.eot) begin
            crc_next   = CRC_INIT;
            bytes_next = '0;
          end else begin
            drop_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Control state and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      crc        <= CRC_INIT;
      bytes_out  <= '0;
      error_drop <= 1'b0;
      capacity   <= CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      crc        <= crc_next;
      bytes_out  <= bytes_next;
      error_drop <= drop_next;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (can_emit) begin
        out_valid <= emit;
      end
    end
  end

  // Working token and the output register.
  always_ff @(posedge clk) begin
    cur <= cur_next;
    err <= err_next;
    idx <= idx_next;
    if (can_emit && emit) begin
      kind           <= e_kind;
      data_byte      <= e_byte;
      status         <= e_status;
      decoded_length <= (e_kind == KIND_STATUS) ? 24'(bytes_out) : '0;
      last           <= e_kind;
    end
  end

endmodule

@@ tb/radix64_armor_decoder_crc24_tb.sv @@
// Self-checking testbench for the radix-64 armor decoder with CRC-24 check.
`timescale 1ns / 1ps

module radix64_armor_decoder_crc24_tb;
  import r64arm_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE      = 20;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [6:0] NOT_SYMBOL  = 7'h40;

  // Ways a generated message can be damaged.
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_SYMBOL,
    FLAW_HIGH_BIT,
    FLAW_PARTIAL,
    FLAW_NO_CRC,
    FLAW_SHORT_CRC,
    FLAW_LONG_CRC,
    FLAW_WRONG_CRC,
    FLAW_CRC_SYMBOL
  } flaw_t;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_val;
    status_t     code;
    logic [23:0] length;
    logic        last;
  } out_beat_t;

  logic        clk;
  logic        rst            = 1'b1;
  logic        cfg_write      = 1'b0;
  logic [23:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in        = '0;
  logic        end_of_text    = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [2:0]  status;
  logic [23:0] decoded_length;
  logic        last;

  radix64_armor_decoder_crc24 uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_in        (char_in),
    .end_of_text    (end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .status         (status),
    .decoded_length (decoded_length),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Text waiting to be sent, and decoder beats still owed by the block.
  text_beat_t armor_text_q[$];
  out_beat_t  armor_out_q[$];

  int chars_pending  = 0;
  int queued_chars   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  bit in_taken       = 1'b0;
  int in_gap         = 0;
  int stall_left     = 0;
  int gap_odds       = 0;
  int stall_odds     = 0;
  bit calm           = 1'b0;

  // Decoder state as the block should hold it.
  logic [23:0] dec_capacity = CAP_RESET;
  logic        dec_line_start;
  logic        dec_in_check;
  logic        dec_stopped;
  logic        dec_dropping;
  logic [6:0]  dec_group [4];
  logic [1:0]  dec_gcount;
  logic [6:0]  dec_check [4];
  logic [2:0]  dec_ccount;
  logic [23:0] dec_crc;
  logic [23:0] dec_bytes;

  // 6-bit value of an alphabet character; NOT_SYMBOL for anything else.
  function automatic logic [6:0] r64_value(input logic [6:0] c);
    logic [7:0] x;
    x = {1'b0, c};
    if (x >= CH_UP_A && x <= CH_UP_Z) return 7'(x - CH_UP_A);
    if (x >= CH_LO_A && x <= CH_LO_Z) return 7'(x - CH_LO_A + 8'd26);
    if (x >= CH_ZERO && x <= CH_NINE) return 7'(x - CH_ZERO + 8'd52);
    if (x == CH_PLUS) return 7'd62;
    if (x == CH_SLASH) return 7'd63;
    return NOT_SYMBOL;
  endfunction

  // Alphabet character for a 6-bit value, used when building armored text.
  function automatic logic [7:0] r64_char(input logic [5:0] v);
    if (v < 6'd26) return CH_UP_A + 8'(v);
    if (v < 6'd52) return CH_LO_A + 8'(v - 6'd26);
    if (v < 6'd62) return CH_ZERO + 8'(v - 6'd52);
    return (v == SYM_PLUS_VAL) ? CH_PLUS : CH_SLASH;
  endfunction

  // CRC-24 over one byte, most significant bit first.
  function automatic logic [23:0] crc24_step(input logic [23:0] crc, input logic [7:0] b);
    logic fb;
    crc = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      fb  = crc[23];
      crc = {crc[22:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY[23:0];
      end
    end
    return crc;
  endfunction

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.push_back(s[i]);
    end
    return t;
  endfunction

  task automatic restart_message();
    dec_line_start = 1'b1;
    dec_in_check   = 1'b0;
    dec_stopped    = 1'b0;
    dec_dropping   = 1'b0;
    dec_gcount     = '0;
    dec_ccount     = '0;
    dec_crc        = CRC_INIT;
    dec_bytes      = '0;
    for (int i = 0; i < 4; i++) begin
      dec_group[i] = '0;
      dec_check[i] = '0;
    end
  endtask

  task automatic push_out(input logic k, input logic [7:0] d, input status_t s,
                          input logic [23:0] len, input logic l);
    out_beat_t b;
    b.kind     = k;
    b.data_val = d;
    b.code     = s;
    b.length   = len;
    b.last     = l;
    armor_out_q.push_back(b);
  endtask

  // Advance the decoder by one character and queue the beats it owes.
  task automatic armor_decode_char(input logic [7:0] c, input logic eot);
    status_t     err;
    logic [23:0] room;
    logic [23:0] sum;
    logic [6:0]  v [4];
    logic [7:0]  d [3];
    logic        bad;
    int          nb;
    err = ST_OK;
    if (dec_dropping) begin
      if (eot) begin
        restart_message();
      end
      return;
    end
    if (!dec_stopped) begin
      if (c[7]) begin
        err = ST_HIGH_BIT;
      end else if (c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        // Blank characters are skipped.
      end else if (c == CH_LF) begin
        dec_line_start = 1'b1;
      end else if (dec_in_check) begin
        // A new non-blank line after the checksum line stops the text.
        if (dec_line_start) begin
          dec_stopped = 1'b1;
        end else if (dec_ccount >= CHECK_LEN) begin
          err = ST_CRC_OVERLONG;
        end else begin
          dec_check[dec_ccount[1:0]] = c[6:0];
          dec_ccount = dec_ccount + 3'd1;
        end
      end else if (dec_line_start && c == CH_EQ) begin
        dec_line_start = 1'b0;
        dec_in_check   = 1'b1;
      end else begin
        dec_line_start = 1'b0;
        dec_group[dec_gcount] = c[6:0];
        if (dec_gcount != GROUP_LAST) begin
          dec_gcount = dec_gcount + 2'd1;
        end else begin
          // Full group: capacity first, then symbols and padding.
          dec_gcount = '0;
          room = (dec_capacity > dec_bytes) ? dec_capacity - dec_bytes : 24'd0;
          for (int i = 0; i < 4; i++) begin
            v[i] = r64_value(dec_group[i]);
          end
          if (dec_group[2] == CH_EQ[6:0]) begin
            bad = v[0][6] | v[1][6];
            nb  = 1;
          end else if (dec_group[3] == CH_EQ[6:0]) begin
            bad = v[0][6] | v[1][6] | v[2][6];
            nb  = 2;
          end else begin
            bad = v[0][6] | v[1][6] | v[2][6] | v[3][6];
            nb  = 3;
          end
          if (room < 24'd3) begin
            err = ST_OUTPUT_FULL;
          end else if (bad) begin
            err = ST_BAD_SYMBOL;
          end else begin
            d[0] = {v[0][5:0], v[1][5:4]};
            d[1] = {v[1][3:0], v[2][5:2]};
            d[2] = {v[2][1:0], v[3][5:0]};
            for (int i = 0; i < nb; i++) begin
              dec_crc = crc24_step(dec_crc, d[i]);
              push_out(KIND_DATA, d[i], ST_OK, 24'd0, 1'b0);
            end
            dec_bytes = dec_bytes + 24'(nb);
          end
        end
      end
    end
    // Closing checks on the end character.
    if (err == ST_OK && eot) begin
      if (dec_gcount != 2'd0) begin
        err = ST_PARTIAL;
      end else if (dec_ccount != CHECK_LEN) begin
        err = ST_CRC_MISSING;
      end else begin
        sum = '0;
        bad = 1'b0;
        for (int i = 0; i < 4; i++) begin
          v[0] = r64_value(dec_check[i]);
          bad  = bad | v[0][6];
          sum  = {sum[17:0], v[0][5:0]};
        end
        if (bad || sum != dec_crc) begin
          err = ST_CRC_MISMATCH;
        end
      end
    end
    if (err != ST_OK || eot) begin
      push_out(KIND_STATUS, 8'h00, err, dec_bytes, 1'b1);
      if (eot) begin
        restart_message();
      end else begin
        dec_dropping = 1'b1;
      end
    end
  endtask

  task automatic queue_text(input text_t txt, input bit close);
    text_beat_t b;
    for (int i = 0; i < txt.size(); i++) begin
      b.ch  = txt[i];
      b.eot = close && (i == txt.size() - 1);
      armor_text_q.push_back(b);
      chars_pending++;
      queued_chars++;
    end
  endtask

  // Armor a byte string with its checksum line, optionally damaged.
  task automatic queue_message(input text_t data, input flaw_t flaw);
    text_t       txt;
    logic [23:0] crc;
    logic [23:0] w;
    logic [7:0]  ck [4];
    int          per_line;
    int          groups;
    int          n;
    int          idx;
    crc      = CRC_INIT;
    per_line = $urandom_range(1, 4);
    groups   = 0;
    foreach (data[i]) begin
      crc = crc24_step(crc, data[i]);
    end
    for (int pos = 0; pos < data.size(); pos += 3) begin
      n = data.size() - pos;
      if (n > 3) n = 3;
      w = {data[pos], 16'h0000};
      if (n > 1) w[15:8] = data[pos + 1];
      if (n > 2) w[7:0] = data[pos + 2];
      txt.push_back(r64_char(w[23:18]));
      txt.push_back(r64_char(w[17:12]));
      txt.push_back((n > 1) ? r64_char(w[11:6]) : CH_EQ);
      txt.push_back((n > 2) ? r64_char(w[5:0]) : CH_EQ);
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: txt.push_back(CH_SPACE);
          1: txt.push_back(CH_TAB);
          2: txt.push_back(CH_CR);
          default: txt.push_back(CH_NUL);
        endcase
      end
      groups++;
      if (groups % per_line == 0) begin
        if ($urandom_range(0, 1)) txt.push_back(CH_CR);
        txt.push_back(CH_LF);
      end
    end

    // Damage to the body.
    idx = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
    case (flaw)
      FLAW_BAD_SYMBOL: begin
        if (txt.size() == 0) txt.push_back(CH_STAR);
        else txt[idx] = $urandom_range(0, 1) ? CH_STAR : CH_EQ;
      end
      FLAW_HIGH_BIT: begin
        if (txt.size() == 0) txt.push_back(8'h80);
        else txt[idx] = 8'h80 | 8'($urandom_range(0, 127));
      end
      FLAW_PARTIAL: begin
        repeat ($urandom_range(1, 3)) txt.push_back(r64_char(6'($urandom_range(0, 63))));
      end
      default: ;
    endcase

    // Checksum line.
    if (flaw != FLAW_NO_CRC) begin
      if (txt.size() == 0 || txt[txt.size() - 1] != CH_LF) txt.push_back(CH_LF);
      txt.push_back(CH_EQ);
      if (flaw == FLAW_WRONG_CRC) crc = crc ^ (24'd1 << $urandom_range(0, 23));
      for (int k = 0; k < 4; k++) begin
        ck[k] = r64_char(6'(crc >> (18 - 6 * k)));
      end
      if (flaw == FLAW_CRC_SYMBOL) ck[$urandom_range(0, 3)] = $urandom_range(0, 1) ? CH_EQ : CH_STAR;
      n = (flaw == FLAW_SHORT_CRC) ? $urandom_range(0, 3) : 4;
      for (int k = 0; k < n; k++) begin
        txt.push_back(ck[k]);
      end
      if (flaw == FLAW_LONG_CRC) txt.push_back(r64_char(6'($urandom_range(0, 63))));
    end

    // Trailer line that the block must ignore after a checksum line, high-bit bytes included.
    if ($urandom_range(0, 1)) begin
      txt.push_back(CH_LF);
      txt.push_back(CH_DASH);
      repeat ($urandom_range(0, 5)) txt.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) txt.push_back(CH_LF);
    queue_text(txt, 1'b1);
  endtask

  // Well-formed and damaged messages in equal shares, with raw noise mixed in.
  task automatic queue_random(input int budget);
    text_t data;
    int    start;
    int    sel;
    int    len;
    start = queued_chars;
    while (queued_chars - start < budget) begin
      sel = $urandom_range(0, 15);
      data.delete();
      if (sel < 2) begin
        repeat ($urandom_range(1, 8)) data.push_back(8'($urandom_range(0, 255)));
        queue_text(data, 1'b1);
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) data.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
          else data.push_back(8'($urandom_range(0, 255)));
        end
        queue_message(data, (sel < 9) ? FLAW_NONE :
                      flaw_t'($urandom_range(FLAW_BAD_SYMBOL, FLAW_CRC_SYMBOL)));
      end
    end
  endtask

  task automatic write_capacity(input logic [23:0] v);
    @(negedge clk);
    cfg_write    = 1'b1;
    cfg_data     = v;
    dec_capacity = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Wait until every character is taken and every owed beat has come back.
  task automatic wait_idle();
    while (chars_pending != 0 || armor_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Stimulus: directed cases, random phases over several capacities, then a calm run.
  initial begin : stimulus
    text_t data;
    restart_message();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    write_capacity(CAP_RESET);

    // High bit at the start of a message, then the rest of the message is dropped.
    data = {8'hFF, 8'h7F};
    queue_text(data, 1'b1);
    // Pad in the fourth place with a good checksum.
    data = {8'h66, 8'h6F};
    queue_message(data, FLAW_NONE);
    // Pad in the third place; the fourth character is never looked at.
    queue_text(to_text("QQ=x"), 1'b1);
    wait_idle();

    // Capacity lowered below the bytes already written in an open message.
    queue_text(to_text("QUJDREVG"), 1'b0);
    wait_idle();
    write_capacity(24'd2);
    queue_text(to_text("R0hJ"), 1'b1);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      gap_odds   = (ph == 2) ? 0 : $urandom_range(1, 6);
      stall_odds = (ph == 3) ? 0 : $urandom_range(1, 6);
      case (ph)
        0: write_capacity(24'd0);
        1: write_capacity(24'd5);
        2: write_capacity(24'($urandom_range(6, 60)));
        3: write_capacity(24'($urandom_range(0, 24'hFFFFFF)));
        default: write_capacity(24'd1024);
      endcase
      queue_random(25);
      wait_idle();
    end

    calm = 1'b1;
    write_capacity(24'hFFFFFF);
    queue_random(30);
    wait_idle();

    if (mismatch_count == 0 && armor_out_q.size() == 0) begin
      $display("PASS radix64_armor_decoder_crc24");
    end else begin
      $display("FAIL radix64_armor_decoder_crc24");
    end
    $finish;
  end

  // Text driver: holds each beat until it is taken, with random gaps between beats.
  always @(negedge clk) begin : text_driver
    text_beat_t b;
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (armor_text_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
        in_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else begin
        b = armor_text_q.pop_front();
        in_valid    <= 1'b1;
        char_in     <= b.ch;
        end_of_text <= b.eot;
      end
    end
  end

  // Result side stalls in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on every taken character and checks every taken result beat.
  always @(posedge clk) begin : monitor
    out_beat_t got;
    out_beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL radix64_armor_decoder_crc24");
      $finish;
    end else begin
      if (!rst && in_valid && !in_stall) begin
        armor_decode_char(char_in, end_of_text);
        in_taken = 1'b1;
        chars_pending--;
      end
      if (!rst && out_valid && !out_stall) begin
        got.kind     = kind;
        got.data_val = data_byte;
        got.code     = status_t'(status);
        got.length   = decoded_length;
        got.last     = last;
        if (armor_out_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected beat: kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                     got.kind, got.data_val, got.code, got.length, got.last);
          end
        end else begin
          want = armor_out_q.pop_front();
          if (got.kind !== want.kind || got.data_val !== want.data_val ||
              got.code !== want.code || got.length !== want.length ||
              got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("beat mismatch: expected kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                       want.kind, want.data_val, want.code, want.length, want.last);
              $display("                    got kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                       got.kind, got.data_val, got.code, got.length, got.last);
            end
          end
        end
      end
    end
  end

endmodule

@@ sim.f @@
design/r64arm_pkg.sv
design/r64arm_front.sv
design/r64arm_queue.sv
design/r64arm_back.sv
design/radix64_armor_decoder_crc24.sv
tb/radix64_armor_decoder_crc24_tb.sv
